[rtl/core/gdc_pkg.sv]
// Shared types and constants for the Gaussian density / CDF pipeline.
// Holds the stage map, fixed-point constants and the per-item pipeline record.
// No dependencies.
`default_nettype none

package gdc_pkg;

    localparam int FRAC_BITS = 16;
    localparam int WORD_BITS = 32;
    localparam int DEN_SHIFT = 2 * FRAC_BITS - 30;
    localparam int CUM_BITS  = FRAC_BITS + 1;

    // register indexes on the config port
    localparam logic CFG_MEAN      = 1'b0;
    localparam logic CFG_DEVIATION = 1'b1;

    // Q30 constants
    localparam logic [30:0] ONE_Q30    = 31'h4000_0000;
    localparam logic [29:0] LN2_Q30    = 30'd744261118;
    localparam logic [28:0] INVS_Q30   = 29'd428361009;
    localparam logic [27:0] B0_Q30     = 28'd248723596;
    // floor(2^40 / LN2_Q30): estimate of w / ln2, low by at most one
    localparam logic [10:0] RECIP_LN2  = 11'd1477;

    // ceil(2^36 / i): exact floor division of a value below 2^31 by i
    localparam logic [36:0] TAY_RECIP [1:13] = '{
        37'd68719476736, 37'd34359738368, 37'd22906492246, 37'd17179869184,
        37'd13743895348, 37'd11453246123, 37'd9817068106,  37'd8589934592,
        37'd7635497416,  37'd6871947674,  37'd6247225158,  37'd5726623062,
        37'd5286113596
    };

    localparam logic signed [33:0] POLY_COEF [5] = '{
        34'sd342933307, -34'sd382857446, 34'sd1912847369, -34'sd1955558716,
        34'sd1428371292
    };

    // stage map
    localparam int ST_ZDIV  = 1;    // 32 stages, one quotient bit of |z| each
    localparam int ST_SQ    = 33;
    localparam int ST_EST   = 34;
    localparam int ST_RED   = 35;
    localparam int ST_FIX   = 36;
    localparam int ST_TAY   = 37;   // 13 terms, two stages each
    localparam int ST_P     = 63;
    localparam int ST_SPLIT = 64;
    localparam int ST_DIV   = 65;   // 31 stages, density and t dividers side by side
    localparam int ST_HORN  = 96;   // 4 Horner steps, two stages each
    localparam int ST_MT    = 104;
    localparam int ST_SG    = 105;
    localparam int ST_MPHI  = 106;
    localparam int ST_FIN   = 107;
    localparam int NST      = 108;

    typedef struct packed {
        logic                 negz;
        logic [30:0]          dev;
        logic                 sat;
        logic [3:0]           mag4;
        logic [31:0]          rz;
        logic [31:0]          qz;
        logic [36:0]          w30;
        logic [32:0]          den;
        logic                 far;
        logic [7:0]           est;
        logic [6:0]           n;
        logic [30:0]          f;
        logic [30:0]          term;
        logic [30:0]          tprod;
        logic signed [34:0]   sum;
        logic [28:0]          p;
        logic [28:0]          phi;
        logic [30:0]          num;
        logic [30:0]          rd;
        logic [30:0]          qd;
        logic [32:0]          rt;
        logic [30:0]          qt;
        logic signed [33:0]   acc;
        logic [32:0]          hm;
        logic                 hneg;
        logic [WORD_BITS-1:0] dens;
        logic [CUM_BITS-1:0]  cum;
    } pipe_t;

endpackage

`default_nettype wire

[rtl/core/gaussian_density_and_cdf.sv]
// Fully pipelined: accepts one item per cycle while no result waits on m_axis_tready.
// Depth is set by the two bit-per-stage dividers (|z|, then density and t in
// parallel), the 13-term exp series and the Horner chain of the CDF polynomial.
// The whole pipe advances together; it holds while a result waits on m_axis_tready.
// Reset (rst_n, async low) clears valid bits; mean resets to 0, deviation to 1.0.
`default_nettype none

module gaussian_density_and_cdf (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [31:0] cfg_wdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [31:0] abscissa
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [55:0]      m_axis_tdata    // [31:0] density, [48:32] cumulative
);

    localparam int NST = gdc_pkg::NST;

    logic signed [31:0] mean_reg;
    logic [30:0]        dev_cfg_reg;

    gdc_pkg::pipe_t pipe_reg  [NST];
    gdc_pkg::pipe_t pipe_next [NST];
    logic [NST-1:0] valid_reg;
    logic           en;

    assign en            = !valid_reg[NST-1] || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = valid_reg[NST-1];
    assign m_axis_tdata  = {7'd0, pipe_reg[NST-1].cum, pipe_reg[NST-1].dens};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mean_reg    <= '0;
            dev_cfg_reg <= 31'(32'd1 << gdc_pkg::FRAC_BITS);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                gdc_pkg::CFG_MEAN:      mean_reg    <= cfg_wdata;
                gdc_pkg::CFG_DEVIATION: dev_cfg_reg <= cfg_wdata[30:0];
                default:                ;
            endcase
        end
    end

    // stage 0: difference, magnitude, range check
    always_comb
    begin
        gdc_pkg::pipe_t s;
        logic signed [32:0] diff;
        logic [32:0]        mag;
        logic [30:0]        dev;
        s    = '0;
        diff = {s_axis_tdata[31], s_axis_tdata} - {mean_reg[31], mean_reg};
        mag  = diff[32] ? 33'(-diff) : 33'(diff);
        dev  = (dev_cfg_reg == '0) ? 31'd1 : dev_cfg_reg;
        s.negz = diff[32];
        s.dev  = dev;
        s.sat  = {2'b00, mag} >= {dev, 4'b0000};
        s.rz   = 32'(mag >> 4);
        s.mag4 = mag[3:0];
        s.qz   = '0;
        pipe_next[0] = s;
    end

    for (genvar k = 1; k < NST; k++)
    begin : g_st
        if (k >= gdc_pkg::ST_ZDIV && k < gdc_pkg::ST_SQ)
        begin : g_zdiv
            always_comb
            begin
                gdc_pkg::pipe_t s;
                logic [32:0] z2;
                logic        b;
                s  = pipe_reg[k-1];
                z2 = {s.rz, s.mag4[3]};
                b  = z2 >= {2'b00, s.dev};
                if (b)
                begin
                    z2 = z2 - {2'b00, s.dev};
                end
                s.mag4 = s.mag4 << 1;
                s.rz   = z2[31:0];
                s.qz   = {s.qz[30:0], b};
                pipe_next[k] = s;
            end
        end
        else if (k == gdc_pkg::ST_SQ)
        begin : g_sq
            always_comb
            begin
                gdc_pkg::pipe_t s;
                logic [31:0] z;
                logic [63:0] sq;
                logic [59:0] bz;
                s  = pipe_reg[k-1];
                z  = s.sat ? 32'hFFFF_FFFF : s.qz;
                sq = 64'(z) * 64'(z);
                bz = 60'(gdc_pkg::B0_Q30) * 60'(z);
                s.w30 = sq[63:27];
                s.den = 33'(gdc_pkg::ONE_Q30) + 33'(bz[59:28]);
                pipe_next[k] = s;
            end
        end
        else if (k == gdc_pkg::ST_EST)
        begin : g_est
            always_comb
            begin
                gdc_pkg::pipe_t s;
                logic [47:0] ep;
                s  = pipe_reg[k-1];
                ep = 48'(s.w30) * 48'(gdc_pkg::RECIP_LN2);
                s.est = ep[47:40];
                s.far = s.w30[36];
                pipe_next[k] = s;
            end
        end
        else if (k == gdc_pkg::ST_RED)
        begin : g_red
            always_comb
            begin
                gdc_pkg::pipe_t s;
                logic [37:0] rp;
                logic [37:0] f0;
                s  = pipe_reg[k-1];
                rp = 38'(s.est) * 38'(gdc_pkg::LN2_Q30);
                f0 = 38'(s.w30) - rp;
                s.f = f0[30:0];
                pipe_next[k] = s;
            end
        end
        else if (k == gdc_pkg::ST_FIX)
        begin : g_fix
            always_comb
            begin
                gdc_pkg::pipe_t s;
                s = pipe_reg[k-1];
                if (s.f >= 31'(gdc_pkg::LN2_Q30))
                begin
                    s.f = s.f - 31'(gdc_pkg::LN2_Q30);
                    s.n = s.est[6:0] + 7'd1;
                end
                else
                begin
                    s.n = s.est[6:0];
                end
                if (s.far)
                begin
                    s.n = '0;
                end
                s.term = gdc_pkg::ONE_Q30;
                s.sum  = 35'(gdc_pkg::ONE_Q30);
                pipe_next[k] = s;
            end
        end
        else if (k >= gdc_pkg::ST_TAY && k < gdc_pkg::ST_P)
        begin : g_tay
            localparam int TI = (k - gdc_pkg::ST_TAY) / 2 + 1;
            if (((k - gdc_pkg::ST_TAY) % 2) == 0)
            begin : g_mul
                always_comb
                begin
                    gdc_pkg::pipe_t s;
                    logic [60:0] tp;
                    s  = pipe_reg[k-1];
                    tp = 61'(s.term) * 61'(s.f[29:0]);
                    s.tprod = tp[60:30];
                    pipe_next[k] = s;
                end
            end
            else
            begin : g_div
                always_comb
                begin
                    gdc_pkg::pipe_t s;
                    logic [67:0] dq;
                    logic signed [34:0] tv;
                    s  = pipe_reg[k-1];
                    dq = 68'(s.tprod) * 68'(gdc_pkg::TAY_RECIP[TI]);
                    s.term = dq[66:36];
                    tv = $signed({4'b0000, s.term});
                    // odd terms of exp(-f) subtract
                    s.sum = ((TI % 2) == 1) ? (s.sum - tv) : (s.sum + tv);
                    pipe_next[k] = s;
                end
            end
        end
        else if (k == gdc_pkg::ST_P)
        begin : g_p
            always_comb
            begin
                gdc_pkg::pipe_t s;
                logic [30:0] m;
                logic [59:0] pp;
                s = pipe_reg[k-1];
                if (s.far || s.sum < 0)
                begin
                    m = '0;
                end
                else if (s.sum > 35'(gdc_pkg::ONE_Q30))
                begin
                    m = gdc_pkg::ONE_Q30;
                end
                else
                begin
                    m = s.sum[30:0];
                end
                pp  = 60'(m) * 60'(gdc_pkg::INVS_Q30);
                s.p = pp[58:30];
                pipe_next[k] = s;
            end
        end
        else if (k == gdc_pkg::ST_SPLIT)
        begin : g_split
            always_comb
            begin
                gdc_pkg::pipe_t s;
                s     = pipe_reg[k-1];
                s.phi = s.p >> s.n;
                if (s.n <= 7'(gdc_pkg::DEN_SHIFT))
                begin
                    s.num = 31'(s.p) << (7'(gdc_pkg::DEN_SHIFT) - s.n);
                end
                else
                begin
                    s.num = 31'(s.p >> (s.n - 7'(gdc_pkg::DEN_SHIFT)));
                end
                s.rd  = '0;
                s.qd  = '0;
                s.rt  = 33'(33'd1 << 29);   // 2^60 >> 31
                s.qt  = '0;
                s.acc = gdc_pkg::POLY_COEF[4];
                pipe_next[k] = s;
            end
        end
        else if (k >= gdc_pkg::ST_DIV && k < gdc_pkg::ST_HORN)
        begin : g_div
            always_comb
            begin
                gdc_pkg::pipe_t s;
                logic [31:0] d2;
                logic [33:0] t2;
                logic        db;
                logic        tb;
                s  = pipe_reg[k-1];
                d2 = {s.rd, s.num[30]};
                db = d2 >= {1'b0, s.dev};
                if (db)
                begin
                    d2 = d2 - {1'b0, s.dev};
                end
                s.num = s.num << 1;
                s.rd  = d2[30:0];
                s.qd  = {s.qd[29:0], db};
                t2 = {s.rt, 1'b0};
                tb = t2 >= {1'b0, s.den};
                if (tb)
                begin
                    t2 = t2 - {1'b0, s.den};
                end
                s.rt = t2[32:0];
                s.qt = {s.qt[29:0], tb};
                pipe_next[k] = s;
            end
        end
        else if ((k >= gdc_pkg::ST_HORN && k < gdc_pkg::ST_MT
                  && ((k - gdc_pkg::ST_HORN) % 2) == 0) || k == gdc_pkg::ST_MT)
        begin : g_mt
            always_comb
            begin
                gdc_pkg::pipe_t s;
                logic [32:0] am;
                logic [63:0] hp;
                s  = pipe_reg[k-1];
                am = s.acc[33] ? 33'(-s.acc) : 33'(s.acc);
                hp = 64'(am) * 64'(s.qt);
                s.hm   = hp[62:30];
                s.hneg = s.acc[33];
                pipe_next[k] = s;
            end
        end
        else if (k > gdc_pkg::ST_HORN && k < gdc_pkg::ST_MT)
        begin : g_add
            localparam int HI = 3 - (k - gdc_pkg::ST_HORN) / 2;
            always_comb
            begin
                gdc_pkg::pipe_t s;
                logic signed [33:0] hv;
                s  = pipe_reg[k-1];
                hv = s.hneg ? -$signed({1'b0, s.hm}) : $signed({1'b0, s.hm});
                s.acc = gdc_pkg::POLY_COEF[HI] + hv;
                pipe_next[k] = s;
            end
        end
        else if (k == gdc_pkg::ST_SG)
        begin : g_sg
            always_comb
            begin
                gdc_pkg::pipe_t s;
                s = pipe_reg[k-1];
                s.acc = s.hneg ? -$signed({1'b0, s.hm}) : $signed({1'b0, s.hm});
                pipe_next[k] = s;
            end
        end
        else if (k == gdc_pkg::ST_MPHI)
        begin : g_mphi
            always_comb
            begin
                gdc_pkg::pipe_t s;
                logic [32:0] am;
                logic [63:0] hp;
                s  = pipe_reg[k-1];
                am = s.acc[33] ? 33'(-s.acc) : 33'(s.acc);
                hp = 64'(am) * 64'(s.phi);
                s.hm   = hp[62:30];
                s.hneg = s.acc[33];
                pipe_next[k] = s;
            end
        end
        else
        begin : g_fin
            always_comb
            begin
                gdc_pkg::pipe_t s;
                logic signed [33:0] hv;
                logic signed [34:0] pc;
                logic [30:0]        pcu;
                logic [31:0]        rr;
                s  = pipe_reg[k-1];
                hv = s.hneg ? -$signed({1'b0, s.hm}) : $signed({1'b0, s.hm});
                pc = $signed({4'b0000, gdc_pkg::ONE_Q30}) - {hv[33], hv};
                if (pc < 0)
                begin
                    pcu = '0;
                end
                else if (pc > $signed({4'b0000, gdc_pkg::ONE_Q30}))
                begin
                    pcu = gdc_pkg::ONE_Q30;
                end
                else
                begin
                    pcu = pc[30:0];
                end
                // left tail mirrors the right one
                if (s.negz)
                begin
                    pcu = gdc_pkg::ONE_Q30 - pcu;
                end
                rr     = 32'(pcu) + 32'(32'd1 << (29 - gdc_pkg::FRAC_BITS));
                s.cum  = rr[30 -: gdc_pkg::CUM_BITS];
                s.dens = gdc_pkg::WORD_BITS'(s.qd);
                pipe_next[k] = s;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[NST-2:0], s_axis_tvalid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NST; i++)
            begin
                pipe_reg[i] <= pipe_next[i];
            end
        end
    end

`ifndef SYNTH
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input taken while output stalled");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> valid_reg[0])
        else $error("accepted item missing from first stage");

    a_cum_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[48:32] <= 17'd65536))
        else $error("cumulative above one");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(valid_reg))
        else $error("pipeline moved during stall");
`endif

endmodule

`default_nettype wire

[dv/gdc_checker.sv]
// Checker for gaussian_density_and_cdf: tracks config writes, predicts density and
// cumulative for every accepted abscissa and compares them against the output stream.
// Depends on gdc_pkg for register indexes and widths.
module gdc_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_wdata,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [55:0] m_axis_tdata,
    output int          fail_count,
    output int          outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] Q30 = 64'd1 << 30;
    localparam longint HORNER_K [5] = '{
        342933307, -382857446, 1912847369, -1955558716, 1428371292
    };

    typedef struct packed {
        logic [gdc_pkg::WORD_BITS-1:0] dens;
        logic [gdc_pkg::CUM_BITS-1:0]  cum;
    } gauss_t;

    logic signed [31:0] mean_q;
    logic [30:0]        dev_q;
    gauss_t             gauss_q [$];

    // signed Q30 times unsigned Q30, truncated toward zero
    function automatic longint q30_mul(longint a, logic [63:0] b);
        logic [63:0] mag;
        logic [63:0] r;
        mag = (a < 0) ? -a : a;
        r = (mag * b) >> 30;
        return (a < 0) ? -longint'(r) : longint'(r);
    endfunction

    function automatic gauss_t gauss_eval(logic signed [31:0] x);
        longint      d, sum, acc, pc;
        logic        negz;
        logic [63:0] mag, dev, q, r, frac, z28, w30, m, p, phi, den, t, dens, f, term;
        int          n, s, i;
        gauss_t      g;
        d = longint'(x) - longint'(mean_q);
        negz = d < 0;
        mag = negz ? -d : d;
        dev = (dev_q == 0) ? 64'd1 : 64'(dev_q);
        q = mag / dev;
        frac = 0;
        if (q >= 16)
            z28 = 64'hFFFF_FFFF;
        else
        begin
            r = mag % dev;
            for (i = 0; i < 28; i++)
            begin
                r = r << 1;
                frac = frac << 1;
                if (r >= dev)
                begin
                    r = r - dev;
                    frac = frac | 1;
                end
            end
            z28 = (q << 28) | frac;
        end
        w30 = (z28 * z28) >> 27;
        m = 0;
        n = 0;
        if (w30 < (64'd64 << 30))
        begin
            n = int'(w30 / 64'(gdc_pkg::LN2_Q30));
            f = w30 - 64'(n) * 64'(gdc_pkg::LN2_Q30);
            term = Q30;
            sum = longint'(Q30);
            for (i = 1; i <= 13; i++)
            begin
                term = ((term * f) >> 30) / 64'(i);
                if (i & 1)
                    sum -= longint'(term);
                else
                    sum += longint'(term);
            end
            if (sum < 0)
                sum = 0;
            if (sum > longint'(Q30))
                sum = longint'(Q30);
            m = 64'(sum);
        end
        p = (m * 64'(gdc_pkg::INVS_Q30)) >> 30;
        s = 2 * gdc_pkg::FRAC_BITS - 30 - n;
        if (s >= 0)
            dens = (p << s) / dev;
        else
            dens = (-s >= 64) ? 64'd0 : (p >> (-s)) / dev;
        if (dens > 64'hFFFF_FFFF)
            dens = 64'hFFFF_FFFF;
        phi = (n < 64) ? (p >> n) : 64'd0;
        den = Q30 + ((64'(gdc_pkg::B0_Q30) * z28) >> 28);
        t = (64'd1 << 60) / den;
        acc = HORNER_K[4];
        for (i = 3; i >= 0; i--)
            acc = HORNER_K[i] + q30_mul(acc, t);
        acc = q30_mul(acc, t);
        pc = longint'(Q30) - q30_mul(acc, phi);
        if (pc < 0)
            pc = 0;
        if (pc > longint'(Q30))
            pc = longint'(Q30);
        if (negz)
            pc = longint'(Q30) - pc;
        g.dens = dens[31:0];
        g.cum = gdc_pkg::CUM_BITS'((64'(pc) + (64'd1 << (29 - gdc_pkg::FRAC_BITS)))
                                   >> (30 - gdc_pkg::FRAC_BITS));
        return g;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    assign outstanding = gauss_q.size();

    initial
        fail_count = 0;

    always @(posedge clk or negedge rst_n)
    begin
        gauss_t want;
        if (!rst_n)
        begin
            mean_q <= '0;
            dev_q <= 31'd1 << gdc_pkg::FRAC_BITS;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == gdc_pkg::CFG_MEAN)
                    mean_q <= cfg_wdata;
                else
                    dev_q <= cfg_wdata[30:0];
            end
            if (s_axis_tvalid && s_axis_tready)
                gauss_q.push_back(gauss_eval(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (gauss_q.size() == 0)
                    report_mismatch("unexpected item", m_axis_tdata, 0);
                else
                begin
                    want = gauss_q.pop_front();
                    if (m_axis_tdata[31:0] !== want.dens)
                        report_mismatch("density", m_axis_tdata[31:0], want.dens);
                    if (m_axis_tdata[48:32] !== want.cum)
                        report_mismatch("cumulative", m_axis_tdata[48:32], want.cum);
                end
            end
        end
    end
endmodule

[dv/tb_gaussian_density_and_cdf.sv]
// Top of the gaussian_density_and_cdf testbench: clock, reset, config phases,
// abscissa stimulus and output backpressure. Checking lives in gdc_checker.
// Depends on gdc_pkg, gdc_checker and the block itself.
module tb_gaussian_density_and_cdf;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN = 130;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        cfg_we = 0;
    logic        cfg_index = gdc_pkg::CFG_MEAN;
    logic [31:0] cfg_wdata = '0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [55:0] m_axis_tdata;
    int          fail_count, outstanding;
    int          sent = 0;
    int          cycles = 0;
    logic        hold_off = 0;
    logic signed [31:0] cur_mean = 0;
    logic [30:0]        cur_dev = 31'd1 << gdc_pkg::FRAC_BITS;

    gaussian_density_and_cdf DUT (.*);
    gdc_checker u_checker (.*);

    always
    begin
        #4 clk = 1;
        #4 clk = 0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // output side: random stall per item plus one long hold
    initial
    begin
        int  gap;
        logic took;
        wait (rst_n);
        forever
        begin
            gap = $urandom_range(0, 8);
            if (gap > 0 || hold_off)
            begin
                m_axis_tready <= 0;
                repeat (gap) @(posedge clk);
                while (hold_off) @(posedge clk);
            end
            m_axis_tready <= 1;
            do
            begin
                @(negedge clk);
                took = m_axis_tvalid && m_axis_tready;
                @(posedge clk);
            end while (!took);
        end
    end

    initial
    begin
        wait (sent == 300);
        hold_off = 1;
        repeat (600) @(posedge clk);
        hold_off = 0;
    end

    task automatic send_x(logic [31:0] x);
        int   gap;
        logic took;
        gap = $urandom_range(0, 8);
        if (gap > 0)
        begin
            s_axis_tvalid <= 0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= x;
        do
        begin
            @(negedge clk);
            took = s_axis_tready;
            @(posedge clk);
        end while (!took);
        sent++;
    endtask

    task automatic settle();
        s_axis_tvalid <= 0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic set_reg(logic idx, logic [31:0] v);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 0;
        if (idx == gdc_pkg::CFG_MEAN)
            cur_mean = v;
        else
            cur_dev = v[30:0];
    endtask

    // mostly points around the mean at a random scale, some anywhere
    function automatic logic [31:0] pick_x();
        longint off;
        int     k;
        if ($urandom_range(0, 9) < 3)
            return $urandom;
        k = $urandom_range(0, 33);
        off = longint'($urandom) % (longint'(cur_dev) * k + 1 + $urandom_range(0, 255));
        if ($urandom_range(0, 1))
            off = -off;
        return 32'(longint'(cur_mean) + off);
    endfunction

    task automatic run_random(int count);
        repeat (count) send_x(pick_x());
    endtask

    initial
    begin
        logic [31:0] edge_x [14];
        edge_x = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'hFFFF_FFFF,
                   32'h0001_0000, 32'hFFFF_0000, 32'h0002_0000, 32'hFFFE_0000,
                   32'h000B_5000, 32'hFFF4_B000, 32'h0010_0000, 32'hFFF0_0000,
                   32'h0008_0000};
        repeat (11) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        foreach (edge_x[i])
            send_x(edge_x[i]);
        run_random(500);
        settle();

        set_reg(gdc_pkg::CFG_MEAN, 32'h7FFF_FFFF);
        set_reg(gdc_pkg::CFG_DEVIATION, 32'hFFFF_FFFF);
        send_x(32'h8000_0000);
        send_x(32'h7FFF_FFFF);
        send_x(32'h0);
        run_random(150);
        settle();

        set_reg(gdc_pkg::CFG_MEAN, 32'h8000_0000);
        set_reg(gdc_pkg::CFG_DEVIATION, 32'h0);
        send_x(32'h8000_0000);
        send_x(32'h8000_0001);
        send_x(32'h7FFF_FFFF);
        run_random(150);
        settle();

        set_reg(gdc_pkg::CFG_DEVIATION, 32'h1);
        run_random(150);
        settle();

        set_reg(gdc_pkg::CFG_MEAN, $urandom);
        set_reg(gdc_pkg::CFG_DEVIATION, 32'($urandom_range(1, 400)));
        run_random(200);
        settle();

        set_reg(gdc_pkg::CFG_MEAN, $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000);
        set_reg(gdc_pkg::CFG_DEVIATION, 32'($urandom_range(32'h4000, 32'h0008_0000)));
        run_random(350);
        settle();

        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

[filelist.f]
rtl/core/gdc_pkg.sv
rtl/core/gaussian_density_and_cdf.sv
dv/gdc_checker.sv
dv/tb_gaussian_density_and_cdf.sv
